// ===== rtl/array_table_sort_search_top_macros.svh =====
// Assertion helpers for the array store block
`ifndef ARRAY_TABLE_SORT_SEARCH_TOP_MACROS_SVH
`define ARRAY_TABLE_SORT_SEARCH_TOP_MACROS_SVH

// implication check, reset-qualified
`define ATSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle check, reset-qualified
`define ATSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/atss_pkg.sv =====
package atss_pkg;

    localparam logic [2:0] REQ_CLEAR    = 3'd0;
    localparam logic [2:0] REQ_INSERT   = 3'd1;
    localparam logic [2:0] REQ_DELETE   = 3'd2;
    localparam logic [2:0] REQ_SORT_UP  = 3'd3;
    localparam logic [2:0] REQ_SORT_DN  = 3'd4;
    localparam logic [2:0] REQ_LSEARCH  = 3'd5;
    localparam logic [2:0] REQ_BSEARCH  = 3'd6;
    localparam logic [2:0] REQ_READ     = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  found_position;
        logic signed [31:0] data_out;
        logic [7:0]  count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_SRT_RDI,
        S_SRT_RDJ,
        S_SRT_CMP,
        S_SRT_WRJ,
        S_LS_RD,
        S_LS_CMP,
        S_BS_RD,
        S_BS_CMP,
        S_DONE
    } state_t;

endpackage

// ===== rtl/atss_mem.sv =====
module atss_mem #(
    parameter int AW = 7
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [31:0]   wdata,
    input  logic [AW-1:0]        raddr,
    output logic signed [31:0]   rdata
);
    logic signed [31:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/atss_cmp.sv =====
// shared compare unit: signed order and equality
module atss_cmp (
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               lt,
    output logic               eq
);
    assign lt = a < b;
    assign eq = a == b;
endmodule

// ===== rtl/array_table_sort_search_top.sv =====
// Sequencing: clear and errors go straight to done; read is a single memory read;
// insert/delete move items one by one; linear search reads items in order until a
// match or the end; sort is an exchange sort on a memory with one read and one write
// port; binary search first sorts the table, then probes it.
// Throughput: one item at a time; busy is high through done; next start is taken the cycle after.
// Reset: asynchronous active-low clears count and sequencer; memory is not cleared.
module array_table_sort_search_top #(
    parameter int DEPTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  atss_pkg::req_t   req,
    output logic             done,
    output atss_pkg::rsp_t   rsp
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // width that holds both the 8-bit position and the count
    localparam int XW = (CW >= 8) ? CW + 1 : 9;

    atss_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic signed [31:0] a_reg, a_next;
    logic [2:0]    op_reg, op_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    logic [1:0]    st_reg, st_next;
    logic [6:0]    fp_reg, fp_next;
    logic signed [31:0] dat_reg, dat_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic signed [31:0] wdata, rdata;
    logic               lt, eq;
    logic signed [31:0] ca, cb;
    logic [CW:0]        mid;
    logic [7:0]         pos_in;
    logic [XW-1:0]      pos_x, cnt_x;

    atss_mem #(.AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    atss_cmp u_cmp (.a(ca), .b(cb), .lt(lt), .eq(eq));

    assign mid    = (lo_reg + hi_reg) >> 1;
    assign pos_in = req.position;
    assign pos_x  = XW'(pos_in);
    assign cnt_x  = XW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atss_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        a_reg   <= a_next;
        op_reg  <= op_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        fp_reg  <= fp_next;
        dat_reg <= dat_next;
    end

    // compare operand selection for the shared unit
    always_comb
    begin
        ca = a_reg;
        cb = rdata;
        case (state_reg)
            atss_pkg::S_SRT_CMP:
            begin
                // ascending swaps when e[j] < e[i]
                if (op_reg == atss_pkg::REQ_SORT_DN)
                begin
                    ca = a_reg;
                    cb = rdata;
                end
                else
                begin
                    ca = rdata;
                    cb = a_reg;
                end
            end
            atss_pkg::S_BS_CMP:
            begin
                ca = rdata;
                cb = val_reg;
            end
            default:
            begin
                ca = rdata;
                cb = val_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atss_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type)
                        atss_pkg::REQ_INSERT:
                            if (count_reg >= CW'(DEPTH) || pos_x > cnt_x)
                                state_next = atss_pkg::S_DONE;
                            else if (CW'(pos_in) == count_reg)
                                state_next = atss_pkg::S_INS_WR;
                            else
                                state_next = atss_pkg::S_INS_RD;
                        atss_pkg::REQ_DELETE:
                            if (pos_x >= cnt_x ||
                                CW'(pos_in) + CW'(1) == count_reg)
                                state_next = atss_pkg::S_DONE;
                            else
                                state_next = atss_pkg::S_DEL_RD;
                        atss_pkg::REQ_SORT_UP, atss_pkg::REQ_SORT_DN,
                        atss_pkg::REQ_BSEARCH:
                            if (count_reg > CW'(1))
                                state_next = atss_pkg::S_SRT_RDI;
                            else if (req.req_type == atss_pkg::REQ_BSEARCH &&
                                     count_reg != '0)
                                state_next = atss_pkg::S_BS_RD;
                            else
                                state_next = atss_pkg::S_DONE;
                        atss_pkg::REQ_LSEARCH:
                            if (count_reg != '0)
                                state_next = atss_pkg::S_LS_RD;
                            else
                                state_next = atss_pkg::S_DONE;
                        atss_pkg::REQ_READ:
                            if (pos_x >= cnt_x)
                                state_next = atss_pkg::S_DONE;
                            else
                                state_next = atss_pkg::S_LS_CMP;
                        default:
                            state_next = atss_pkg::S_DONE;
                    endcase
                end
            end
            atss_pkg::S_INS_RD:  state_next = atss_pkg::S_INS_WR;
            atss_pkg::S_INS_WR:
                if (i_reg == pos_reg)
                    state_next = atss_pkg::S_DONE;
                else if (i_reg - CW'(1) == pos_reg)
                    state_next = atss_pkg::S_INS_WR;
                else
                    state_next = atss_pkg::S_INS_RD;
            atss_pkg::S_DEL_RD:  state_next = atss_pkg::S_DEL_WR;
            atss_pkg::S_DEL_WR:
                // count_reg already holds the reduced count
                if (i_reg + CW'(1) >= count_reg)
                    state_next = atss_pkg::S_DONE;
                else
                    state_next = atss_pkg::S_DEL_RD;
            atss_pkg::S_SRT_RDI: state_next = atss_pkg::S_SRT_RDJ;
            atss_pkg::S_SRT_RDJ: state_next = atss_pkg::S_SRT_CMP;
            atss_pkg::S_SRT_CMP:
                if (lt)
                    state_next = atss_pkg::S_SRT_WRJ;
                else if (j_reg + CW'(1) < count_reg)
                    state_next = atss_pkg::S_SRT_CMP;
                else if (i_reg + CW'(2) < count_reg)
                    state_next = atss_pkg::S_SRT_RDI;
                else if (op_reg == atss_pkg::REQ_BSEARCH)
                    state_next = atss_pkg::S_BS_RD;
                else
                    state_next = atss_pkg::S_DONE;
            atss_pkg::S_SRT_WRJ:
                if (j_reg + CW'(1) < count_reg)
                    state_next = atss_pkg::S_SRT_CMP;
                else if (i_reg + CW'(2) < count_reg)
                    state_next = atss_pkg::S_SRT_RDI;
                else if (op_reg == atss_pkg::REQ_BSEARCH)
                    state_next = atss_pkg::S_BS_RD;
                else
                    state_next = atss_pkg::S_DONE;
            atss_pkg::S_LS_RD: state_next = atss_pkg::S_LS_CMP;
            atss_pkg::S_LS_CMP:
                if (op_reg == atss_pkg::REQ_READ || eq || i_reg + CW'(1) >= count_reg)
                    state_next = atss_pkg::S_DONE;
            atss_pkg::S_BS_RD: state_next = atss_pkg::S_BS_CMP;
            atss_pkg::S_BS_CMP:
                if (eq)
                    state_next = atss_pkg::S_DONE;
                else if (lt ? (mid + 1'b1 > hi_reg) : (mid == lo_reg))
                    state_next = atss_pkg::S_DONE;
                else
                    state_next = atss_pkg::S_BS_RD;
            atss_pkg::S_DONE: state_next = atss_pkg::S_IDLE;
            default: state_next = atss_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        count_next = count_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        a_next   = a_reg;
        op_next  = op_reg;
        pos_next = pos_reg;
        val_next = val_reg;
        st_next  = st_reg;
        fp_next  = fp_reg;
        dat_next = dat_reg;
        we    = 1'b0;
        waddr = AW'(i_reg);
        wdata = a_reg;
        raddr = AW'(i_reg);
        case (state_reg)
            atss_pkg::S_IDLE:
            begin
                op_next  = req.req_type;
                pos_next = CW'(pos_in);
                val_next = req.value;
                st_next  = atss_pkg::ST_OK;
                fp_next  = '0;
                dat_next = '0;
                i_next   = '0;
                j_next   = CW'(1);
                lo_next  = '0;
                hi_next  = (CW+1)'(count_reg) - 1'b1;
                raddr    = AW'(pos_in);
                if (start)
                begin
                    case (req.req_type)
                        atss_pkg::REQ_CLEAR: count_next = '0;
                        atss_pkg::REQ_INSERT:
                            if (count_reg >= CW'(DEPTH))
                                st_next = atss_pkg::ST_FULL;
                            else if (pos_x > cnt_x)
                                st_next = atss_pkg::ST_BADPOS;
                            else
                            begin
                                i_next = count_reg;
                                raddr  = AW'(count_reg - CW'(1));
                                if (CW'(pos_in) == count_reg)
                                    a_next = req.value;
                            end
                        atss_pkg::REQ_DELETE:
                            if (pos_x >= cnt_x)
                                st_next = atss_pkg::ST_BADPOS;
                            else
                            begin
                                i_next = CW'(pos_in);
                                count_next = count_reg - CW'(1);
                            end
                        atss_pkg::REQ_LSEARCH:
                        begin
                            if (count_reg == '0)
                                st_next = atss_pkg::ST_NOTFOUND;
                        end
                        atss_pkg::REQ_SORT_UP, atss_pkg::REQ_SORT_DN,
                        atss_pkg::REQ_BSEARCH:
                            if (count_reg == '0 && req.req_type == atss_pkg::REQ_BSEARCH)
                                st_next = atss_pkg::ST_NOTFOUND;
                        atss_pkg::REQ_READ:
                            if (pos_x >= cnt_x)
                                st_next = atss_pkg::ST_BADPOS;
                            else
                                i_next = CW'(pos_in);
                        default: ;
                    endcase
                end
            end
            atss_pkg::S_INS_RD:
            begin
                raddr = AW'(i_reg - CW'(1));
            end
            atss_pkg::S_INS_WR:
            begin
                we    = 1'b1;
                waddr = AW'(i_reg);
                if (i_reg == pos_reg)
                begin
                    wdata = val_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    wdata  = rdata;
                    i_next = i_reg - CW'(1);
                    raddr  = AW'(i_reg - CW'(2));
                end
            end
            atss_pkg::S_DEL_RD:
                raddr = AW'(i_reg + CW'(1));
            atss_pkg::S_DEL_WR:
            begin
                we    = 1'b1;
                waddr = AW'(i_reg);
                wdata = rdata;
                i_next = i_reg + CW'(1);
            end
            atss_pkg::S_SRT_RDI:
            begin
                raddr  = AW'(i_reg);
                j_next = i_reg + CW'(1);
            end
            atss_pkg::S_SRT_RDJ:
            begin
                a_next = rdata;
                raddr  = AW'(j_reg);
            end
            atss_pkg::S_SRT_CMP:
            begin
                // rdata holds e[j]; a_reg holds e[i]
                if (lt)
                begin
                    we     = 1'b1;
                    waddr  = AW'(i_reg);
                    wdata  = rdata;
                    a_next = rdata;
                    dat_next = a_reg;
                    raddr  = AW'(j_reg);
                end
                else if (j_reg + CW'(1) < count_reg)
                begin
                    j_next = j_reg + CW'(1);
                    raddr  = AW'(j_reg + CW'(1));
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    raddr  = AW'(i_reg + CW'(1));
                    lo_next = '0;
                    hi_next = (CW+1)'(count_reg) - 1'b1;
                    dat_next = '0;
                end
            end
            atss_pkg::S_SRT_WRJ:
            begin
                // complete swap: old e[i] into slot j
                we    = 1'b1;
                waddr = AW'(j_reg);
                wdata = dat_reg;
                dat_next = '0;
                if (j_reg + CW'(1) < count_reg)
                begin
                    j_next = j_reg + CW'(1);
                    raddr  = AW'(j_reg + CW'(1));
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    j_next = i_reg + CW'(2);
                    raddr  = AW'(i_reg + CW'(1));
                    lo_next = '0;
                    hi_next = (CW+1)'(count_reg) - 1'b1;
                end
            end
            atss_pkg::S_LS_RD:
                raddr = AW'(i_reg);
            atss_pkg::S_LS_CMP:
            begin
                if (op_reg == atss_pkg::REQ_READ)
                    dat_next = rdata;
                else if (eq)
                    fp_next = 7'(i_reg);
                else if (i_reg + CW'(1) >= count_reg)
                    st_next = atss_pkg::ST_NOTFOUND;
                else
                begin
                    i_next = i_reg + CW'(1);
                    raddr  = AW'(i_reg + CW'(1));
                end
            end
            atss_pkg::S_BS_RD:
                raddr = AW'(mid);
            atss_pkg::S_BS_CMP:
            begin
                if (eq)
                    fp_next = 7'(mid);
                else if (lt)
                begin
                    lo_next = mid + 1'b1;
                    if (mid + 1'b1 > hi_reg)
                        st_next = atss_pkg::ST_NOTFOUND;
                end
                else
                begin
                    hi_next = mid - 1'b1;
                    if (mid == lo_reg)
                        st_next = atss_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    assign busy = state_reg != atss_pkg::S_IDLE;
    assign done = state_reg == atss_pkg::S_DONE;

    always_comb
    begin
        rsp.status         = st_reg;
        rsp.found_position = fp_reg;
        rsp.data_out       = (op_reg == atss_pkg::REQ_READ) ? dat_reg : '0;
        rsp.count          = 8'(count_reg);
    end
endmodule

// ===== rtl/atss_checker.sv =====
`include "array_table_sort_search_top_macros.svh"

module atss_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input atss_pkg::rsp_t rsp
);
    `ATSS_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "done while not busy")
    `ATSS_ASSERT_NXT(a_done_one, clk, rst_n, done, !done, "done held two cycles")
    `ATSS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after accept")
    `ATSS_ASSERT_IMP(a_count_rng, clk, rst_n, done, rsp.count <= 8'd128, "count out of range")
endmodule

bind array_table_sort_search_top atss_checker u_atss_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
